[design/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[design/siim_pkg.sv]
package siim_pkg;

    localparam int VALUE_W = 32;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int ADDR_W  = 3;

    // phase codes
    localparam logic [1:0] PH_OPEN   = 2'd0;  // new interval not placed yet
    localparam logic [1:0] PH_MERGE  = 2'd1;  // pending merged interval held
    localparam logic [1:0] PH_PLACED = 2'd2;

    // register index codes
    localparam logic REG_NEW_START = 1'b0;
    localparam logic REG_NEW_END   = 1'b1;

    typedef struct packed {
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        logic               last;
    } siim_res_t;

    // one queue entry: all results caused by one request
    typedef struct packed {
        logic      two;
        siim_res_t r0;
        siim_res_t r1;
    } siim_entry_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } siim_qstat_t;

endpackage

[design/sorted_interval_insert_merge_unit.sv]
// Channel   Dir  Handshake          Payload
// s_*       in   s_valid/s_ready    s_iv_start, s_iv_end, s_is_last, s_empty_list
// m_*       out  m_valid/m_ready    m_out_start, m_out_end, m_out_last
// apb       in   psel/penable/...   reg 0 new_start @0x0, reg 1 new_end @0x4
//
// One request per cycle is accepted while the 4-entry result queue has room.
// The front classifies a request in its accept cycle; the back sends
// an entry's one or two results in turn, each held until m_ready takes it. Results
// pass the queue, then the back's current-entry register; reset (aresetn, sync,
// low) clears phase, queue and output valid. Either side may stall freely.
`include "assert_macros.svh"

module sorted_interval_insert_merge_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic [siim_pkg::VALUE_W-1:0]  s_iv_start,
    input  logic [siim_pkg::VALUE_W-1:0]  s_iv_end,
    input  logic                          s_is_last,
    input  logic                          s_empty_list,
    input  logic                          s_valid,
    output logic                          s_ready,
    // result channel
    output logic [siim_pkg::VALUE_W-1:0]  m_out_start,
    output logic [siim_pkg::VALUE_W-1:0]  m_out_end,
    output logic                          m_out_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [siim_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import siim_pkg::*;

    // interval to insert
    logic [VALUE_W-1:0] new_start_reg, new_start_next;
    logic [VALUE_W-1:0] new_end_reg, new_end_next;
    logic               cfg_wr;
    logic               reg_sel;

    siim_entry_t        f_entry, q_entry;
    siim_qstat_t        q_stat;
    logic               f_push, b_pop;
    logic [1:0]         phase;
    logic               s_accept;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign reg_sel  = paddr[2];
    assign s_accept = s_valid && s_ready;

    always_comb begin
        new_start_next = new_start_reg;
        new_end_next   = new_end_reg;
        if (cfg_wr) begin
            unique case (reg_sel)
                REG_NEW_START: new_start_next = pwdata[VALUE_W-1:0];
                REG_NEW_END:   new_end_next   = pwdata[VALUE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_NEW_START: prdata = new_start_reg;
            REG_NEW_END:   prdata = new_end_reg;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            new_start_reg <= '0;
            new_end_reg   <= '0;
        end else begin
            new_start_reg <= new_start_next;
            new_end_reg   <= new_end_next;
        end
    end

    // front: accept and classify, update merge state
    siim_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_iv_start   (s_iv_start),
        .s_iv_end     (s_iv_end),
        .s_is_last    (s_is_last),
        .s_empty_list (s_empty_list),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .new_start    (new_start_reg),
        .new_end      (new_end_reg),
        .q_full       (q_stat.full),
        .push         (f_push),
        .entry        (f_entry),
        .phase        (phase)
    );

    // decouples classification from output back-pressure
    siim_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (f_push),
        .din     (f_entry),
        .pop     (b_pop),
        .dout    (q_entry),
        .stat    (q_stat)
    );

    // back: serialize one or two results per entry
    siim_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_entry     (q_entry),
        .q_empty     (q_stat.empty),
        .pop         (b_pop),
        .m_out_start (m_out_start),
        .m_out_end   (m_out_end),
        .m_out_last  (m_out_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

    // queue never overfills
    `ASSERT_IMPLY(a_q_bound, aclk, aresetn, 1'b1, q_stat.count <= QCNT_W'(QDEPTH))
    // back only pops when something is queued
    `ASSERT_IMPLY(a_pop_nonempty, aclk, aresetn, b_pop, !q_stat.empty)
    // a list terminator always resets the phase
    `ASSERT_NEXT(a_last_phase, aclk, aresetn, s_accept && (s_is_last || s_empty_list), phase == PH_OPEN)
    // empty-list request always produces a result somewhere downstream
    `ASSERT_NEXT(a_empty_res, aclk, aresetn, s_accept && s_empty_list, !q_stat.empty || m_valid)

endmodule

[design/siim_front.sv]
module siim_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [siim_pkg::VALUE_W-1:0]  s_iv_start,
    input  logic [siim_pkg::VALUE_W-1:0]  s_iv_end,
    input  logic                          s_is_last,
    input  logic                          s_empty_list,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [siim_pkg::VALUE_W-1:0]  new_start,
    input  logic [siim_pkg::VALUE_W-1:0]  new_end,
    input  logic                          q_full,
    output logic                          push,
    output siim_pkg::siim_entry_t         entry,
    output logic [1:0]                    phase
);
    import siim_pkg::*;

    logic [1:0]         phase_reg, phase_next;
    logic [VALUE_W-1:0] mrg_lo_reg, mrg_lo_next;
    logic [VALUE_W-1:0] mrg_hi_reg, mrg_hi_next;
    logic               accept;
    logic               e_lt_ns, ne_lt_s, me_lt_s;
    logic [VALUE_W-1:0] open_lo, open_hi, grow_lo, grow_hi;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign phase   = phase_reg;

    assign e_lt_ns = $signed(s_iv_end) < $signed(new_start);
    assign ne_lt_s = $signed(new_end) < $signed(s_iv_start);
    assign me_lt_s = $signed(mrg_hi_reg) < $signed(s_iv_start);

    // first overlap: fold list interval with the new one
    assign open_lo = ($signed(new_start) < $signed(s_iv_start)) ? new_start : s_iv_start;
    assign open_hi = ($signed(s_iv_end) < $signed(new_end)) ? new_end : s_iv_end;
    // further overlap: grow the pending interval
    assign grow_lo = ($signed(s_iv_start) < $signed(mrg_lo_reg)) ? s_iv_start : mrg_lo_reg;
    assign grow_hi = ($signed(mrg_hi_reg) < $signed(s_iv_end)) ? s_iv_end : mrg_hi_reg;

    always_comb begin
        phase_next  = phase_reg;
        mrg_lo_next = mrg_lo_reg;
        mrg_hi_next = mrg_hi_reg;
        push        = 1'b0;
        entry       = '0;
        if (accept) begin
            if (s_empty_list) begin
                push        = 1'b1;
                entry.r0    = '{lo: new_start, hi: new_end, last: 1'b1};
                phase_next  = PH_OPEN;
            end else begin
                unique case (phase_reg)
                    PH_OPEN: begin
                        if (e_lt_ns) begin
                            push      = 1'b1;
                            entry.r0  = '{lo: s_iv_start, hi: s_iv_end, last: 1'b0};
                            entry.two = s_is_last;
                            entry.r1  = '{lo: new_start, hi: new_end, last: 1'b1};
                        end else if (ne_lt_s) begin
                            push       = 1'b1;
                            entry.two  = 1'b1;
                            entry.r0   = '{lo: new_start, hi: new_end, last: 1'b0};
                            entry.r1   = '{lo: s_iv_start, hi: s_iv_end, last: s_is_last};
                            phase_next = PH_PLACED;
                        end else begin
                            mrg_lo_next = open_lo;
                            mrg_hi_next = open_hi;
                            phase_next  = PH_MERGE;
                            push        = s_is_last;
                            entry.r0    = '{lo: open_lo, hi: open_hi, last: 1'b1};
                        end
                    end
                    PH_MERGE: begin
                        if (me_lt_s) begin
                            push       = 1'b1;
                            entry.two  = 1'b1;
                            entry.r0   = '{lo: mrg_lo_reg, hi: mrg_hi_reg, last: 1'b0};
                            entry.r1   = '{lo: s_iv_start, hi: s_iv_end, last: s_is_last};
                            phase_next = PH_PLACED;
                        end else begin
                            mrg_lo_next = grow_lo;
                            mrg_hi_next = grow_hi;
                            push        = s_is_last;
                            entry.r0    = '{lo: grow_lo, hi: grow_hi, last: 1'b1};
                        end
                    end
                    default: begin
                        // placed, and the unused code behaves the same
                        push       = 1'b1;
                        entry.r0   = '{lo: s_iv_start, hi: s_iv_end, last: s_is_last};
                        phase_next = PH_PLACED;
                    end
                endcase
                if (s_is_last) begin
                    phase_next = PH_OPEN;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_OPEN;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mrg_lo_reg <= '0;
            mrg_hi_reg <= '0;
        end else begin
            mrg_lo_reg <= mrg_lo_next;
            mrg_hi_reg <= mrg_hi_next;
        end
    end

endmodule

[design/siim_queue.sv]
module siim_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  siim_pkg::siim_entry_t   din,
    input  logic                    pop,
    output siim_pkg::siim_entry_t   dout,
    output siim_pkg::siim_qstat_t   stat
);
    import siim_pkg::*;

    siim_entry_t       mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign dout       = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

[design/siim_back.sv]
module siim_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  siim_pkg::siim_entry_t         q_entry,
    input  logic                          q_empty,
    output logic                          pop,
    output logic [siim_pkg::VALUE_W-1:0]  m_out_start,
    output logic [siim_pkg::VALUE_W-1:0]  m_out_end,
    output logic                          m_out_last,
    output logic                          m_valid,
    input  logic                          m_ready
);
    import siim_pkg::*;

    siim_entry_t cur_reg, cur_next;
    logic        cur_valid_reg, cur_valid_next;
    logic        sub_reg, sub_next;
    logic        fire, done, load;
    siim_res_t   sel;

    assign fire = cur_valid_reg && m_ready;
    assign done = fire && (sub_reg || !cur_reg.two);
    assign load = !cur_valid_reg || done;
    assign pop  = load && !q_empty;

    assign sel         = sub_reg ? cur_reg.r1 : cur_reg.r0;
    assign m_valid     = cur_valid_reg;
    assign m_out_start = sel.lo;
    assign m_out_end   = sel.hi;
    assign m_out_last  = sel.last;

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        sub_next       = sub_reg;
        if (load) begin
            cur_valid_next = pop;
            sub_next       = 1'b0;
            if (pop) begin
                cur_next = q_entry;
            end
        end else if (fire) begin
            sub_next = 1'b1;  // second result of a two-result entry
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

endmodule

[test/siim_checker.sv]
`timescale 1ns / 1ps

module siim_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [siim_pkg::VALUE_W-1:0] s_iv_start,
    input  logic [siim_pkg::VALUE_W-1:0] s_iv_end,
    input  logic                         s_is_last,
    input  logic                         s_empty_list,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [siim_pkg::VALUE_W-1:0] m_out_start,
    input  logic [siim_pkg::VALUE_W-1:0] m_out_end,
    input  logic                         m_out_last,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [siim_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready,
    output int                           errors,
    output int                           pending,
    output int                           results
);
    import siim_pkg::*;

    localparam logic [ADDR_W-1:0] LO_ADDR = {REG_NEW_START, 2'b00};
    localparam logic [ADDR_W-1:0] HI_ADDR = {REG_NEW_END, 2'b00};

    siim_res_t                 due_q[$];
    logic signed [VALUE_W-1:0] win_lo, win_hi;   // interval being inserted
    logic signed [VALUE_W-1:0] run_lo, run_hi;   // pending merged interval
    logic [1:0]                placement;
    int                        err_cnt, res_cnt;

    task automatic due(input logic [VALUE_W-1:0] lo, hi, input logic fin);
        siim_res_t r;
        r.lo   = lo;
        r.hi   = hi;
        r.last = fin;
        due_q  = {due_q, r};
    endtask

    // one request against the current placement state
    task automatic fold_request(input logic signed [VALUE_W-1:0] a, b,
                                input logic fin, emp);
        if (emp) begin
            due(win_lo, win_hi, 1'b1);
            placement = PH_OPEN;
            return;
        end
        case (placement)
            PH_OPEN: begin
                if (b < win_lo) begin
                    due(a, b, 1'b0);
                    if (fin) due(win_lo, win_hi, 1'b1);
                end else if (win_hi < a) begin
                    due(win_lo, win_hi, 1'b0);
                    due(a, b, fin);
                    placement = PH_PLACED;
                end else begin
                    run_lo    = (a < win_lo) ? a : win_lo;
                    run_hi    = (b < win_hi) ? win_hi : b;
                    placement = PH_MERGE;
                    if (fin) due(run_lo, run_hi, 1'b1);
                end
            end
            PH_MERGE: begin
                if (run_hi < a) begin
                    due(run_lo, run_hi, 1'b0);
                    due(a, b, fin);
                    placement = PH_PLACED;
                end else begin
                    if (a < run_lo) run_lo = a;
                    if (run_hi < b) run_hi = b;
                    if (fin) due(run_lo, run_hi, 1'b1);
                end
            end
            default: begin
                due(a, b, fin);
                placement = PH_PLACED;
            end
        endcase
        if (fin) placement = PH_OPEN;
    endtask

    always @(posedge aclk) begin : watch
        siim_res_t   want;
        logic [31:0] rd_want;
        if (!aresetn) begin
            due_q.delete();
            win_lo    = '0;
            win_hi    = '0;
            run_lo    = '0;
            run_hi    = '0;
            placement = PH_OPEN;
            err_cnt   = 0;
            res_cnt   = 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == LO_ADDR) win_lo = pwdata;
                    else if (paddr == HI_ADDR) win_hi = pwdata;
                end else begin
                    rd_want = (paddr == HI_ADDR) ? win_hi : win_lo;
                    if (prdata !== rd_want) begin
                        $display("%0t: readback @%0h exp %h got %h", $time, paddr,
                                 rd_want, prdata);
                        err_cnt++;
                    end
                end
            end
            // results first: nothing accepted at this edge can already be out
            if (m_valid && m_ready) begin
                res_cnt++;
                if (due_q.size() == 0) begin
                    $display("%0t: unexpected result %0d..%0d last %b", $time,
                             $signed(m_out_start), $signed(m_out_end), m_out_last);
                    err_cnt++;
                end else begin
                    want = due_q.pop_front();
                    if (m_out_start !== want.lo) begin
                        $display("%0t: out_start exp %0d got %0d", $time,
                                 $signed(want.lo), $signed(m_out_start));
                        err_cnt++;
                    end
                    if (m_out_end !== want.hi) begin
                        $display("%0t: out_end exp %0d got %0d", $time,
                                 $signed(want.hi), $signed(m_out_end));
                        err_cnt++;
                    end
                    if (m_out_last !== want.last) begin
                        $display("%0t: out_last exp %b got %b", $time, want.last,
                                 m_out_last);
                        err_cnt++;
                    end
                end
            end
            if (s_valid && s_ready)
                fold_request(s_iv_start, s_iv_end, s_is_last, s_empty_list);
        end
        errors  <= err_cnt;
        pending <= due_q.size();
        results <= res_cnt;
    end

endmodule

[test/tb_sorted_interval_insert_merge_unit.sv]
`timescale 1ns / 1ps

module tb_sorted_interval_insert_merge_unit;
    import siim_pkg::*;

    localparam int ITEMS       = 2000;        // random requests to offer
    localparam int LIMIT       = 500_000;     // hang guard, in cycles
    localparam int SETTLE      = 8;           // pipeline latency plus margin
    localparam int HOLD_CYCLES = 300;         // long receiver back-pressure

    localparam logic [ADDR_W-1:0] LO_ADDR = {REG_NEW_START, 2'b00};
    localparam logic [ADDR_W-1:0] HI_ADDR = {REG_NEW_END, 2'b00};

    localparam logic signed [31:0] VMIN   = 32'sh8000_0000;
    localparam logic signed [31:0] VMAX   = 32'sh7fff_ffff;
    localparam logic signed [63:0] VMIN_L = -64'sd2147483648;
    localparam logic signed [63:0] VMAX_L = 64'sd2147483647;

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic [VALUE_W-1:0] s_iv_start   = '0;
    logic [VALUE_W-1:0] s_iv_end     = '0;
    logic               s_is_last    = 1'b0;
    logic               s_empty_list = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [VALUE_W-1:0] m_out_start;
    logic [VALUE_W-1:0] m_out_end;
    logic               m_out_last;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [ADDR_W-1:0]  paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic [31:0]        prdata;
    logic               pready;

    int errors, pending, results;
    int cycles   = 0;
    int sent     = 0;
    int lists    = 0;
    int settings = 0;

    bit no_idle     = 1'b0;   // phase with back-to-back traffic on both sides
    bit rx_hold_req = 1'b0;   // asks the receiver for one long stall

    // stimulus-side copy of the insert window, used only to aim the lists
    logic signed [31:0] cur_lo = '0;
    logic signed [31:0] cur_hi = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sorted_interval_insert_merge_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_iv_start   (s_iv_start),
        .s_iv_end     (s_iv_end),
        .s_is_last    (s_is_last),
        .s_empty_list (s_empty_list),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .m_out_start  (m_out_start),
        .m_out_end    (m_out_end),
        .m_out_last   (m_out_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    siim_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_iv_start   (s_iv_start),
        .s_iv_end     (s_iv_end),
        .s_is_last    (s_is_last),
        .s_empty_list (s_empty_list),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .m_out_start  (m_out_start),
        .m_out_end    (m_out_end),
        .m_out_last   (m_out_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .errors       (errors),
        .pending      (pending),
        .results      (results)
    );

    // hang guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("sorted_interval_insert_merge_unit verification failed");
            $finish;
        end
    end

    // Result side: a random stall before each result, none in no_idle
    // phases. One long stall on request, counted here, lets the result queue
    // fill so the block drops s_ready while requests keep coming.
    initial begin
        int w;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            w = no_idle ? 0 : $urandom_range(0, 5);
            if (w != 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Offer one request; valid stays up with a fixed payload until taken.
    // Valid is left high afterwards so back-to-back requests need no drop.
    task automatic offer(input logic [31:0] a, b, input logic fin, emp);
        int w;
        w = no_idle ? 0 : $urandom_range(0, 5);
        if (w != 0) begin
            s_valid <= 1'b0;
            repeat (w) @(posedge aclk);
        end
        s_iv_start   <= a;
        s_iv_end     <= b;
        s_is_last    <= fin;
        s_empty_list <= emp;
        s_valid      <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    // Stop sending and wait until every predicted result is back. pending
    // is registered, hence the first wait. Requests that produce no result
    // may still be in the pipe, so add the latency on top.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // APB setup + access; pready is tied high so the access phase never waits
    task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] a,
                              input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // New insert window, only with the block idle; both registers read back.
    task automatic set_window(input logic signed [31:0] lo, hi);
        wait_drained();
        reg_access(1'b1, LO_ADDR, lo);
        reg_access(1'b1, HI_ADDR, hi);
        reg_access(1'b0, LO_ADDR, '0);
        reg_access(1'b0, HI_ADDR, '0);
        cur_lo = lo;
        cur_hi = hi;
        settings++;
    endtask

    // Well-formed list: sorted, non-overlapping, laid around the window start
    // so the window lands before, inside or after it. Small steps give lots
    // of touching and multi-interval merges; large steps sweep the upper bits.
    // With cut set, an empty-list request replaces one interval and ends it.
    task automatic sorted_list(input int n, input bit cut);
        logic signed [63:0] step, span, lo, cur, st, en;
        int cut_at;
        case ($urandom_range(0, 2))
            0:       step = $urandom_range(1, 4);
            1:       step = 64'sd1 <<< $urandom_range(4, 12);
            default: step = 64'sd1 <<< $urandom_range(13, 24);
        endcase
        span = n * (2 * step + 1);
        // signed offsets keep a negative window start sign-extended
        lo   = cur_lo - longint'($urandom_range(0, span)) + longint'($urandom_range(0, step));
        if (lo > VMAX_L - span) lo = VMAX_L - span;
        if (lo < VMIN_L) lo = VMIN_L;
        cut_at = cut ? $urandom_range(0, n - 1) : n;
        cur    = lo;
        lists++;
        for (int i = 0; i < n; i++) begin
            if (i == cut_at) begin
                offer($urandom, $urandom, $urandom_range(0, 1), 1'b1);
                return;
            end
            st  = (i == 0) ? cur : cur + 1 + $urandom_range(0, step - 1);
            en  = st + $urandom_range(0, step);
            cur = en;
            offer(st[31:0], en[31:0], i == n - 1, 1'b0);
        end
    endtask

    initial begin
        logic signed [63:0] lo_l, hi_l, len;
        int n;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed, with the reset window 0..0 ----
        offer(VMAX, VMIN, 1'b0, 1'b1);      // empty list, junk fields, is_last low
        offer(-20, -10, 1'b0, 1'b0);        // ends before the window: passes
        offer(-5, 0, 1'b0, 1'b0);           // end touches window start: merge
        offer(0, 3, 1'b0, 1'b0);            // start touches pending end: grows
        offer(8, 9, 1'b1, 1'b0);            // after: pending out first, then last
        offer(VMIN, VMIN + 1, 1'b1, 1'b0);  // whole list before: window appended
        offer(1, 2, 1'b0, 1'b0);            // window placed ahead of first item
        offer(VMAX - 1, VMAX, 1'b1, 1'b0);  // passes after placement
        offer(-3, 4, 1'b0, 1'b0);           // starts a merge ...
        offer($urandom, $urandom, 1'b1, 1'b1);  // ... dropped by an empty list
        offer(-1, 1, 1'b1, 1'b0);           // single item merged and closed
        offer(5, 6, 1'b0, 1'b0);            // unsorted list from here on
        offer(-100, -50, 1'b0, 1'b0);
        offer(0, 0, 1'b1, 1'b0);
        set_window(100, 50);                // reversed window
        offer(60, 70, 1'b0, 1'b0);
        offer(80, 120, 1'b1, 1'b0);
        set_window(VMIN, VMAX);             // window covering everything
        offer(0, 5, 1'b1, 1'b0);
        offer(VMIN, VMAX, 1'b0, 1'b1);

        // ---- random phases, one insert window each ----
        for (int k = 0; sent < ITEMS + 20; k++) begin
            case (k % 8)
                0: set_window(VMIN, VMIN);
                1: set_window(VMAX, VMAX);
                2: set_window(VMIN, VMAX);
                3: set_window(0, 0);
                default: begin
                    lo_l = $signed($urandom);
                    len  = $urandom_range(0, 1) ? $urandom_range(0, 8)
                                                : $urandom_range(0, 1 << $urandom_range(3, 20));
                    // one phase in eight runs a reversed window
                    hi_l = (k % 8 == 4) ? lo_l - len : lo_l + len;
                    if (hi_l > VMAX_L) hi_l = VMAX_L;
                    if (hi_l < VMIN_L) hi_l = VMIN_L;
                    set_window(lo_l[31:0], hi_l[31:0]);
                end
            endcase
            no_idle = (k % 4 == 1);
            if (k == 3) rx_hold_req = 1'b1;

            for (int j = 0; j < 20; j++) begin
                // sender goes quiet until every result is back
                if (j == 10) wait_drained();
                n = $urandom_range(1, 8);
                case ($urandom_range(0, 9))
                    0: begin                            // unsorted noise
                        lists++;
                        for (int i = 0; i < n; i++)
                            offer($urandom, $urandom, i == n - 1, 1'b0);
                    end
                    1: begin                            // lone empty list
                        lists++;
                        offer($urandom, $urandom, $urandom_range(0, 1), 1'b1);
                    end
                    2: sorted_list(n, 1'b1);
                    default: sorted_list(n, 1'b0);
                endcase
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d requests in %0d lists under %0d insert windows, %0d results",
                 sent, lists, settings, results);
        $display("incl. extreme windows, touching merges, empty and cut lists, long stall");
        if (errors == 0 && pending == 0) begin
            $display("sorted_interval_insert_merge_unit verification clean");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending);
            $display("sorted_interval_insert_merge_unit verification failed");
        end
        $finish;
    end

endmodule

[sorted_interval_insert_merge_unit.f]
+incdir+design
design/siim_pkg.sv
design/siim_front.sv
design/siim_queue.sv
design/siim_back.sv
design/sorted_interval_insert_merge_unit.sv
test/siim_checker.sv
test/tb_sorted_interval_insert_merge_unit.sv
